// ===== rtl/skf_pkg.sv =====
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

    localparam int GAIN_BITS = 16;
    localparam int DIV_STEPS = GAIN_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 8;

    localparam logic [GAIN_BITS:0]   GAIN_ONE          = {1'b1, {GAIN_BITS{1'b0}}};
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_DINIT,
        S_DIV,
        S_GAIN,
        S_MCORR,
        S_MCOV,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PRED,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_GAIN,
        OP_MUL_CORR,
        OP_MUL_COV,
        OP_WRITE
    } t_dp_op;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== rtl/skf_ctrl.sv =====
// Kalman sequencer: one datapath op per cycle, unless idle or stalled.
module skf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  skf_pkg::t_dp_sts i_sts,
    output skf_pkg::t_dp_op  o_op
);
    import skf_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PRED;
            end
            S_PRED:  n_state = S_DINIT;
            S_DINIT: begin
                n_state = S_DIV;
                n_cnt   = CNT_W'(DIV_STEPS - 1);
            end
            S_DIV: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_GAIN;
            end
            S_GAIN:  n_state = S_MCORR;
            S_MCORR: n_state = S_MCOV;
            S_MCOV:  n_state = S_OUT;
            S_OUT: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_op       = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = OP_LOAD;
            end
            S_PRED:  o_op = OP_PRED;
            S_DINIT: o_op = OP_DIV_INIT;
            S_DIV:   o_op = OP_DIV_STEP;
            S_GAIN:  o_op = OP_GAIN;
            S_MCORR: o_op = OP_MUL_CORR;
            S_MCOV:  o_op = OP_MUL_COV;
            S_OUT: begin
                if (!i_sts.out_busy) o_op = OP_WRITE;
            end
            default: o_op = OP_NONE;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_PRED))
        else $error("accepted item did not start an update");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DINIT) |=> ##16 (r_state == S_GAIN))
        else $error("divider did not run its full step count");

endmodule

// ===== rtl/skf_dpath.sv =====
// Datapath: prediction, serial gain divider, shared multiplier and result register.
module skf_dpath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  skf_pkg::t_dp_op         i_op,
    output skf_pkg::t_dp_sts        o_sts,
    input  logic [31:0]             i_process_noise,
    input  logic [31:0]             i_measure_noise,
    input  logic signed [31:0]      i_measurement,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [31:0]      o_estimate,
    output logic [skf_pkg::GAIN_BITS:0] o_gain
);
    import skf_pkg::*;

    localparam int PROD_W = 33 + GAIN_BITS + 1;

    logic signed [31:0]     r_meas;
    logic signed [31:0]     r_est;
    logic [32:0]            r_cov;
    logic [32:0]            r_pp;
    logic [33:0]            r_den;
    logic [33:0]            r_rem;
    logic [GAIN_BITS-1:0]   r_quo;
    logic [GAIN_BITS:0]     r_gain;
    logic                   r_neg;
    logic [32:0]            r_mag;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_out_valid;
    logic signed [31:0]     r_out_est;
    logic [GAIN_BITS:0]     r_out_gain;

    logic [33:0]            pred_sum;
    logic [32:0]            pp_sat;
    logic [34:0]            div_shift;
    logic [34:0]            div_diff;
    logic                   div_ge;
    logic [GAIN_BITS:0]     gain_val;
    logic signed [32:0]     innov;
    logic [32:0]            mul_a;
    logic [GAIN_BITS:0]     mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [33:0]            corr_mag;
    logic signed [34:0]     corr;
    logic signed [34:0]     est_sum;
    logic signed [31:0]     est_sat;

    assign pred_sum = {1'b0, r_cov} + {2'b00, i_process_noise};
    assign pp_sat   = pred_sum[33] ? '1 : pred_sum[32:0];

    assign div_shift = {r_rem, 1'b0};
    assign div_diff  = div_shift - {1'b0, r_den};
    assign div_ge    = (div_shift >= {1'b0, r_den});

    always_comb begin
        if (r_den == '0)
            gain_val = '0;
        else if (r_den == {1'b0, r_pp})
            gain_val = GAIN_ONE;
        else
            gain_val = {1'b0, r_quo};
    end

    assign innov = {r_meas[31], r_meas} - {r_est[31], r_est};

    always_comb begin
        if (i_op == OP_MUL_COV) begin
            mul_a = r_pp;
            mul_b = GAIN_ONE - r_gain;
        end else begin
            mul_a = r_mag;
            mul_b = r_gain;
        end
    end
    assign mul_p = mul_a * mul_b;

    assign corr_mag = r_prod[PROD_W-1:GAIN_BITS];
    assign corr     = r_neg ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});
    assign est_sum  = 35'(r_est) + corr;

    always_comb begin
        if (est_sum[34:31] != {4{est_sum[34]}})
            est_sat = est_sum[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            est_sat = est_sum[31:0];
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_cov <= '0;
        end else begin
            if (i_op == OP_MUL_COV) r_est <= est_sat;
            if (i_op == OP_WRITE)   r_cov <= r_prod[GAIN_BITS +: 33];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: r_meas <= i_measurement;
            OP_PRED: r_pp   <= pp_sat;
            OP_DIV_INIT: begin
                r_den <= {1'b0, r_pp} + {2'b00, i_measure_noise};
                r_rem <= {1'b0, r_pp};
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? div_diff[33:0] : div_shift[33:0];
                r_quo <= {r_quo[GAIN_BITS-2:0], div_ge};
            end
            OP_GAIN: begin
                r_gain <= gain_val;
                r_neg  <= innov[32];
                r_mag  <= innov[32] ? 33'(-innov) : 33'(innov);
            end
            OP_MUL_CORR: r_prod <= mul_p;
            OP_MUL_COV:  r_prod <= mul_p;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_WRITE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_WRITE) begin
            r_out_est  <= r_est;
            r_out_gain <= r_gain;
        end
    end

    assign o_sts.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_estimate     = r_out_est;
    assign o_gain         = r_out_gain;

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_gain <= GAIN_ONE))
        else $error("gain above one");

    a_cov_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_WRITE) |=> (r_cov <= $past(r_pp)))
        else $error("covariance grew through the update");

endmodule

// ===== rtl/scalar_kalman_filter.sv =====
// One item at a time is in flight; each runs the 16-step restoring gain divider.
// The result register lets the next item be taken while a result waits.
// Reset (synchronous, active low) clears estimate and covariance and
// restores the noise registers to 0.001 and 0.3 in the chosen format.
module scalar_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [31:0]              i_measurement,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [31:0]              o_estimate,
    output logic [skf_pkg::GAIN_BITS:0]     o_gain,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import skf_pkg::*;

    localparam logic [31:0] Q_RESET = 32'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic [31:0] R_RESET = 32'(((3 << FRAC_BITS) + 5) / 10);

    logic [31:0] r_process_noise;
    logic [31:0] r_measure_noise;
    t_dp_op      op;
    t_dp_sts     sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise <= Q_RESET;
            r_measure_noise <= R_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROCESS_NOISE: r_process_noise <= i_cfg_data;
                CFG_MEASURE_NOISE: r_measure_noise <= i_cfg_data;
                default: ;
            endcase
        end
    end

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_op       (op)
    );

    skf_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_sts           (sts),
        .i_process_noise (r_process_noise),
        .i_measure_noise (r_measure_noise),
        .i_measurement   (i_measurement),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_estimate      (o_estimate),
        .o_gain          (o_gain)
    );

endmodule
